// File: sv/one_wire_bus_master_core_macros.svh
// assertion macros for the one-wire bus master
`ifndef ONE_WIRE_BUS_MASTER_CORE_MACROS_SVH
`define ONE_WIRE_BUS_MASTER_CORE_MACROS_SVH

`ifndef SYNTHESIS

// condition must hold in the same cycle as the trigger
`define OWM_ASSERT_SAME(label, clk, rst, trig, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
      else $error(msg);

// condition must hold in the cycle after the trigger
`define OWM_ASSERT_NEXT(label, clk, rst, trig, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
      else $error(msg);

`else

`define OWM_ASSERT_SAME(label, clk, rst, trig, cond, msg)
`define OWM_ASSERT_NEXT(label, clk, rst, trig, cond, msg)

`endif

`endif

// File: sv/owm_pkg.sv
package owm_pkg;

   // operation codes of a request beat
   localparam logic [2:0] OP_TICK       = 3'd0;
   localparam logic [2:0] OP_RESET      = 3'd1;
   localparam logic [2:0] OP_WRITE_BIT  = 3'd2;
   localparam logic [2:0] OP_READ_BIT   = 3'd3;
   localparam logic [2:0] OP_WRITE_BYTE = 3'd4;
   localparam logic [2:0] OP_READ_BYTE  = 3'd5;

   // completion status codes
   localparam logic [1:0] ST_OK          = 2'd0;
   localparam logic [1:0] ST_NO_PRESENCE = 2'd1;
   localparam logic [1:0] ST_PRES_STUCK  = 2'd2;
   localparam logic [1:0] ST_REJECTED    = 2'd3;

   // register indexes
   localparam logic [2:0] CSR_RESET_LOW    = 3'd0;
   localparam logic [2:0] CSR_PRES_TIMEOUT = 3'd1;
   localparam logic [2:0] CSR_PRES_END_TO  = 3'd2;
   localparam logic [2:0] CSR_WR1_LOW      = 3'd3;
   localparam logic [2:0] CSR_WR0_LOW      = 3'd4;
   localparam logic [2:0] CSR_RD_LOW       = 3'd5;
   localparam logic [2:0] CSR_RD_SAMPLE    = 3'd6;
   localparam logic [2:0] CSR_SLOT_TIME    = 3'd7;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 10;

   // register reset values
   localparam logic [9:0] RST_RESET_LOW    = 10'd500;
   localparam logic [9:0] RST_PRES_TIMEOUT = 10'd295;
   localparam logic [9:0] RST_PRES_END_TO  = 10'd240;
   localparam logic [7:0] RST_WR1_LOW      = 8'd8;
   localparam logic [7:0] RST_WR0_LOW      = 8'd60;
   localparam logic [7:0] RST_RD_LOW       = 8'd5;
   localparam logic [7:0] RST_RD_SAMPLE    = 8'd10;
   localparam logic [7:0] RST_SLOT_TIME    = 8'd65;

   // released ticks between reset pulse and presence polling
   localparam logic [10:0] PRESENCE_GAP_TICKS = 11'd5;

   typedef struct packed {
      logic [2:0] operation;
      logic [7:0] write_value;
      logic       line_level;
   } req_payload_type;

   typedef struct packed {
      logic       drive_low;
      logic       busy_res;
      logic       done_res;
      logic [1:0] status;
      logic [7:0] read_data;
   } rsp_payload_type;

endpackage

// File: sv/one_wire_bus_master_core.sv
// One-wire bus master core, timed by one-microsecond tick beats.
// Request channel (req_*): each beat is either a tick carrying the sampled
// bus level, or a command (reset with presence detect, write/read bit,
// write/read byte, bytes LSB first). Commands are taken only while idle; a
// command during a running one returns status "rejected" and changes nothing.
// Response channel (rsp_*): exactly one beat per request beat, giving the
// line drive to apply until the next request, busy, done, status and the
// bits read so far.
// A response beat is valid in the cycle after its request is accepted.
// Throughput: one request per cycle unless stalled; the timing counter and
// shift registers update wholly in one logic pass into the response register.
// Stall: the response register holds while rsp_ready is low; req_ready drops
// only when that register is full and not being taken, so no beat is lost.
// Reset: synchronous, active high; the master goes idle, counters and shift
// registers clear and the timing registers return to their default values.
// Write timing registers via csr_* only while the master is idle (unchecked).
module one_wire_bus_master_core
   import owm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_payload_type       req_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_payload_type       rsp_payload,
   input  logic                  csr_wr_en,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

`include "one_wire_bus_master_core_macros.svh"

   // phase codes
   localparam logic [2:0] PH_IDLE      = 3'd0;
   localparam logic [2:0] PH_RST_LOW   = 3'd1;
   localparam logic [2:0] PH_RST_GAP   = 3'd2;
   localparam logic [2:0] PH_WAIT_LOW  = 3'd3;
   localparam logic [2:0] PH_WAIT_HIGH = 3'd4;
   localparam logic [2:0] PH_SLOT      = 3'd5;

   logic [9:0] reset_low_ff, pres_timeout_ff, pres_end_to_ff;
   logic [7:0] wr1_low_ff, wr0_low_ff, rd_low_ff, rd_sample_ff, slot_time_ff;

   logic [2:0] phase_ff, phase_in;
   logic [2:0] cmd_ff, cmd_in;
   logic [9:0] time_count_ff, time_count_in;
   logic [2:0] bit_index_ff, bit_index_in;
   logic [7:0] send_shift_ff, send_shift_in;
   logic [7:0] recv_shift_ff, recv_shift_in;

   logic            rsp_valid_ff;
   rsp_payload_type rsp_payload_ff, rsp_in;
   logic            accept;

   logic        done, drive, is_cmd, is_read, last_bit, send_bit;
   logic [1:0]  status;
   logic [7:0]  slot_len, len_m1, sample_pt, low_time;
   logic [8:0]  sample_sum;
   logic [10:0] tc_inc;

   // handshake: take a beat whenever the response register can move on
   assign req_ready   = !rsp_valid_ff || rsp_ready;
   assign accept      = req_valid && req_ready;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // timing registers
   always_ff @(posedge clock) begin
      if (reset) begin
         reset_low_ff    <= RST_RESET_LOW;
         pres_timeout_ff <= RST_PRES_TIMEOUT;
         pres_end_to_ff  <= RST_PRES_END_TO;
         wr1_low_ff      <= RST_WR1_LOW;
         wr0_low_ff      <= RST_WR0_LOW;
         rd_low_ff       <= RST_RD_LOW;
         rd_sample_ff    <= RST_RD_SAMPLE;
         slot_time_ff    <= RST_SLOT_TIME;
      end else if (csr_wr_en) begin
         case (csr_addr)
            CSR_RESET_LOW:    reset_low_ff    <= csr_wdata;
            CSR_PRES_TIMEOUT: pres_timeout_ff <= csr_wdata;
            CSR_PRES_END_TO:  pres_end_to_ff  <= csr_wdata;
            CSR_WR1_LOW:      wr1_low_ff      <= csr_wdata[7:0];
            CSR_WR0_LOW:      wr0_low_ff      <= csr_wdata[7:0];
            CSR_RD_LOW:       rd_low_ff       <= csr_wdata[7:0];
            CSR_RD_SAMPLE:    rd_sample_ff    <= csr_wdata[7:0];
            CSR_SLOT_TIME:    slot_time_ff    <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   // next state and response for one request beat
   always_comb begin
      phase_in      = phase_ff;
      cmd_in        = cmd_ff;
      time_count_in = time_count_ff;
      bit_index_in  = bit_index_ff;
      send_shift_in = send_shift_ff;
      recv_shift_in = recv_shift_ff;
      done          = 1'b0;
      status        = ST_OK;
      last_bit      = 1'b0;

      // slot length, sample point clamped to the last tick of the slot
      slot_len   = (slot_time_ff == 8'd0) ? 8'd1 : slot_time_ff;
      len_m1     = slot_len - 8'd1;
      sample_sum = {1'b0, rd_low_ff} + {1'b0, rd_sample_ff};
      sample_pt  = (sample_sum > {1'b0, len_m1}) ? len_m1 : sample_sum[7:0];
      tc_inc     = {1'b0, time_count_ff} + 11'd1;
      is_cmd     = req_payload.operation inside {[OP_RESET:OP_READ_BYTE]};

      if (is_cmd) begin
         if (phase_ff != PH_IDLE) begin
            status = ST_REJECTED;
         end else begin
            cmd_in        = req_payload.operation;
            time_count_in = 10'd0;
            bit_index_in  = 3'd0;
            recv_shift_in = 8'd0;
            send_shift_in = (req_payload.operation == OP_WRITE_BIT) ?
                            {7'd0, req_payload.write_value[0]} : req_payload.write_value;
            phase_in      = (req_payload.operation == OP_RESET) ? PH_RST_LOW : PH_SLOT;
         end
      end else begin
         case (phase_ff)
            PH_RST_LOW: begin
               if (tc_inc >= {1'b0, reset_low_ff}) begin
                  phase_in      = PH_RST_GAP;
                  time_count_in = 10'd0;
               end else begin
                  time_count_in = tc_inc[9:0];
               end
            end
            PH_RST_GAP: begin
               if (tc_inc >= PRESENCE_GAP_TICKS) begin
                  phase_in      = PH_WAIT_LOW;
                  time_count_in = 10'd0;
               end else begin
                  time_count_in = tc_inc[9:0];
               end
            end
            PH_WAIT_LOW: begin
               if ((time_count_ff < pres_timeout_ff) && !req_payload.line_level) begin
                  phase_in      = PH_WAIT_HIGH;
                  time_count_in = 10'd0;
               end else if (tc_inc >= {1'b0, pres_timeout_ff}) begin
                  phase_in      = PH_IDLE;
                  time_count_in = 10'd0;
                  done          = 1'b1;
                  status        = ST_NO_PRESENCE;
               end else begin
                  time_count_in = tc_inc[9:0];
               end
            end
            PH_WAIT_HIGH: begin
               if ((time_count_ff < pres_end_to_ff) && req_payload.line_level) begin
                  phase_in      = PH_IDLE;
                  time_count_in = 10'd0;
                  done          = 1'b1;
               end else if (tc_inc >= {1'b0, pres_end_to_ff}) begin
                  phase_in      = PH_IDLE;
                  time_count_in = 10'd0;
                  done          = 1'b1;
                  status        = ST_PRES_STUCK;
               end else begin
                  time_count_in = tc_inc[9:0];
               end
            end
            PH_SLOT: begin
               // read sample
               if ((cmd_ff == OP_READ_BIT || cmd_ff == OP_READ_BYTE) &&
                   time_count_ff == {2'd0, sample_pt}) begin
                  recv_shift_in[bit_index_ff] = recv_shift_ff[bit_index_ff] |
                                                req_payload.line_level;
               end
               // end of slot: next bit or finish
               if (tc_inc >= {3'd0, slot_len}) begin
                  last_bit = (cmd_ff == OP_WRITE_BIT) || (cmd_ff == OP_READ_BIT) ||
                             (bit_index_ff == 3'd7);
                  if (last_bit) begin
                     phase_in      = PH_IDLE;
                     time_count_in = 10'd0;
                     done          = 1'b1;
                  end else begin
                     bit_index_in  = bit_index_ff + 3'd1;
                     time_count_in = 10'd0;
                  end
               end else begin
                  time_count_in = tc_inc[9:0];
               end
            end
            default: phase_in = PH_IDLE;
         endcase
      end

      // line drive from the updated state
      is_read  = (cmd_in == OP_READ_BIT) || (cmd_in == OP_READ_BYTE);
      send_bit = send_shift_in[bit_index_in];
      low_time = is_read ? rd_low_ff : (send_bit ? wr1_low_ff : wr0_low_ff);
      drive    = (phase_in == PH_RST_LOW) ||
                 ((phase_in == PH_SLOT) && (time_count_in < {2'd0, low_time}));

      rsp_in.drive_low = drive;
      rsp_in.busy_res  = (phase_in != PH_IDLE);
      rsp_in.done_res  = done;
      rsp_in.status    = status;
      rsp_in.read_data = recv_shift_in;
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         cmd_ff        <= OP_TICK;
         time_count_ff <= 10'd0;
         bit_index_ff  <= 3'd0;
         send_shift_ff <= 8'd0;
         recv_shift_ff <= 8'd0;
      end else if (accept) begin
         phase_ff      <= phase_in;
         cmd_ff        <= cmd_in;
         time_count_ff <= time_count_in;
         bit_index_ff  <= bit_index_in;
         send_shift_ff <= send_shift_in;
         recv_shift_ff <= recv_shift_in;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_payload_ff <= rsp_in;
      end
   end

   // checks
   `OWM_ASSERT_SAME(a_done_not_busy, clock, reset, rsp_valid_ff && rsp_payload_ff.done_res, !rsp_payload_ff.busy_res, "done beat still reports busy")
   `OWM_ASSERT_SAME(a_drive_only_busy, clock, reset, rsp_valid_ff && rsp_payload_ff.drive_low, rsp_payload_ff.busy_res, "line driven low while idle")
   `OWM_ASSERT_SAME(a_reject_not_done, clock, reset, rsp_valid_ff && (rsp_payload_ff.status == ST_REJECTED), !rsp_payload_ff.done_res, "rejected beat marked done")
   `OWM_ASSERT_SAME(a_idle_count_clear, clock, reset, phase_ff == PH_IDLE, time_count_ff == 10'd0, "timer not cleared while idle")
   `OWM_ASSERT_SAME(a_bit_index_byte, clock, reset, bit_index_ff != 3'd0, (cmd_ff == OP_WRITE_BYTE) || (cmd_ff == OP_READ_BYTE), "bit index advanced outside a byte command")
   `OWM_ASSERT_NEXT(a_busy_reject_holds, clock, reset, accept && (phase_ff != PH_IDLE) && (req_payload.operation == OP_RESET), phase_ff == $past(phase_ff), "rejected command changed the phase")

endmodule

// File: tb/tb_one_wire_bus_master_core.sv
module tb_one_wire_bus_master_core
   import owm_pkg::*;
();

   // spare operation codes, treated as ticks by the master
   localparam logic [2:0] OP_SPARE_LO = 3'd6;
   localparam logic [2:0] OP_SPARE_HI = 3'd7;

   // cycles with no accepted beat on either side before giving up
   localparam int unsigned WATCHDOG_LIMIT = 1000;

   typedef enum int unsigned {
      PH_IDLE, PH_RST_LOW, PH_RST_GAP, PH_WAIT_LOW, PH_WAIT_HIGH, PH_SLOT
   } bus_phase_type;

   // how the bus answers a reset pulse
   typedef enum int unsigned {
      PRES_ANSWER, PRES_ABSENT, PRES_STUCK, PRES_RANDOM
   } presence_type;

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_payload_type       req_payload = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b1;
   rsp_payload_type       rsp_payload;
   logic                  csr_wr_en = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // master state as predicted
   bus_phase_type bus_phase;
   logic [2:0]    bus_kind;
   int unsigned   tick_count;
   logic [2:0]    bit_pos;
   logic [7:0]    send_byte;
   logic [7:0]    recv_byte;
   int unsigned   timing [8];

   rsp_payload_type expected_beats [$];
   int unsigned     mismatches = 0;
   int unsigned     beats_sent = 0;
   bit              idle_on = 1'b1;
   int unsigned     stall_left = 0;
   int unsigned     quiet_cycles = 0;

   one_wire_bus_master_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_addr    (csr_addr),
      .csr_wdata   (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // predicted state after reset
   function automatic void clear_master();
      timing[CSR_RESET_LOW]    = 32'(RST_RESET_LOW);
      timing[CSR_PRES_TIMEOUT] = 32'(RST_PRES_TIMEOUT);
      timing[CSR_PRES_END_TO]  = 32'(RST_PRES_END_TO);
      timing[CSR_WR1_LOW]      = 32'(RST_WR1_LOW);
      timing[CSR_WR0_LOW]      = 32'(RST_WR0_LOW);
      timing[CSR_RD_LOW]       = 32'(RST_RD_LOW);
      timing[CSR_RD_SAMPLE]    = 32'(RST_RD_SAMPLE);
      timing[CSR_SLOT_TIME]    = 32'(RST_SLOT_TIME);
      bus_phase  = PH_IDLE;
      bus_kind   = '0;
      tick_count = 0;
      bit_pos    = '0;
      send_byte  = '0;
      recv_byte  = '0;
   endfunction

   function automatic bit is_read_cmd();
      return bus_kind == OP_READ_BIT || bus_kind == OP_READ_BYTE;
   endfunction

   function automatic void end_command(inout rsp_payload_type r, input logic [1:0] st);
      bus_phase  = PH_IDLE;
      tick_count = 0;
      r.done_res = 1'b1;
      r.status   = st;
   endfunction

   // one request beat in, the response beat it should give out
   function automatic rsp_payload_type advance_bus_master(input req_payload_type beat);
      rsp_payload_type r;
      int unsigned     len;
      int unsigned     sample;
      int unsigned     low_time;
      r = '0;
      if (beat.operation >= OP_RESET && beat.operation <= OP_READ_BYTE) begin
         if (bus_phase != PH_IDLE) begin
            r.status = ST_REJECTED;
         end else begin
            bus_kind   = beat.operation;
            tick_count = 0;
            bit_pos    = '0;
            recv_byte  = '0;
            send_byte  = (beat.operation == OP_WRITE_BIT) ?
                         {7'd0, beat.write_value[0]} : beat.write_value;
            bus_phase  = (beat.operation == OP_RESET) ? PH_RST_LOW : PH_SLOT;
         end
      end else begin
         case (bus_phase)
            PH_RST_LOW: begin
               if (tick_count + 1 >= timing[CSR_RESET_LOW]) begin
                  bus_phase  = PH_RST_GAP;
                  tick_count = 0;
               end else tick_count++;
            end
            PH_RST_GAP: begin
               if (tick_count + 1 >= 32'(PRESENCE_GAP_TICKS)) begin
                  bus_phase  = PH_WAIT_LOW;
                  tick_count = 0;
               end else tick_count++;
            end
            PH_WAIT_LOW: begin
               if (tick_count < timing[CSR_PRES_TIMEOUT] && !beat.line_level) begin
                  bus_phase  = PH_WAIT_HIGH;
                  tick_count = 0;
               end else begin
                  tick_count++;
                  if (tick_count >= timing[CSR_PRES_TIMEOUT]) end_command(r, ST_NO_PRESENCE);
               end
            end
            PH_WAIT_HIGH: begin
               if (tick_count < timing[CSR_PRES_END_TO] && beat.line_level) begin
                  end_command(r, ST_OK);
               end else begin
                  tick_count++;
                  if (tick_count >= timing[CSR_PRES_END_TO]) end_command(r, ST_PRES_STUCK);
               end
            end
            PH_SLOT: begin
               len    = (timing[CSR_SLOT_TIME] != 0) ? timing[CSR_SLOT_TIME] : 1;
               sample = timing[CSR_RD_LOW] + timing[CSR_RD_SAMPLE];
               if (sample > len - 1) sample = len - 1;
               if (is_read_cmd() && tick_count == sample)
                  recv_byte[bit_pos] = beat.line_level;
               if (tick_count + 1 >= len) begin
                  if (bus_kind == OP_WRITE_BIT || bus_kind == OP_READ_BIT ||
                      bit_pos >= 3'd7) begin
                     end_command(r, ST_OK);
                  end else begin
                     bit_pos++;
                     tick_count = 0;
                  end
               end else tick_count++;
            end
            default: bus_phase = PH_IDLE;
         endcase
      end

      // line drive after this beat
      if (bus_phase == PH_RST_LOW) begin
         r.drive_low = 1'b1;
      end else if (bus_phase == PH_SLOT) begin
         if (is_read_cmd()) low_time = timing[CSR_RD_LOW];
         else low_time = send_byte[bit_pos] ? timing[CSR_WR1_LOW] : timing[CSR_WR0_LOW];
         r.drive_low = (tick_count < low_time);
      end
      r.busy_res  = (bus_phase != PH_IDLE);
      r.read_data = recv_byte;
      return r;
   endfunction

   // request side: optional gap, then hold the beat until it is taken
   task automatic send_beat(input req_payload_type beat);
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= beat;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      expected_beats.push_back(advance_bus_master(beat));
      beats_sent++;
   endtask

   // stop sending and let every expected response arrive
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_beats.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic put_reg(input logic [2:0] idx, input int unsigned value);
      csr_wr_en <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= value[CSR_DATA_W-1:0];
      @(posedge clock);
      timing[idx] = (idx <= CSR_PRES_END_TO) ? (value & 32'h3FF) : (value & 32'hFF);
   endtask

   // rewrite all timing registers while the master is idle
   task automatic load_timing(input int unsigned rst_low, input int unsigned pres_to,
                              input int unsigned pres_end, input int unsigned wr1_low,
                              input int unsigned wr0_low, input int unsigned rd_low,
                              input int unsigned rd_sample, input int unsigned slot);
      settle();
      put_reg(CSR_RESET_LOW, rst_low);
      put_reg(CSR_PRES_TIMEOUT, pres_to);
      put_reg(CSR_PRES_END_TO, pres_end);
      put_reg(CSR_WR1_LOW, wr1_low);
      put_reg(CSR_WR0_LOW, wr0_low);
      put_reg(CSR_RD_LOW, rd_low);
      put_reg(CSR_RD_SAMPLE, rd_sample);
      put_reg(CSR_SLOT_TIME, slot);
      csr_wr_en <= 1'b0;
   endtask

   // bus level seen on the next tick
   function automatic logic pick_level(input presence_type mode);
      case (bus_phase)
         PH_WAIT_LOW: begin
            case (mode)
               PRES_ANSWER, PRES_STUCK: return 1'b0;
               PRES_ABSENT:             return 1'b1;
               default:                 return $urandom_range(0, 99) >= 30;
            endcase
         end
         PH_WAIT_HIGH: begin
            case (mode)
               PRES_ANSWER, PRES_ABSENT: return 1'b1;
               PRES_STUCK:               return 1'b0;
               default:                  return $urandom_range(0, 99) < 30;
            endcase
         end
         default: return 1'($urandom_range(0, 1));
      endcase
   endfunction

   // tick until the running command completes, with stray commands mixed in
   task automatic drain_command(input presence_type mode, input int unsigned noise_pct);
      req_payload_type beat;
      while (bus_phase != PH_IDLE) begin
         beat.write_value = 8'($urandom);
         beat.line_level  = pick_level(mode);
         beat.operation   = ($urandom_range(0, 99) < noise_pct) ?
                            3'($urandom_range(OP_RESET, OP_SPARE_HI)) : OP_TICK;
         send_beat(beat);
      end
   endtask

   task automatic run_command(input logic [2:0] op, input logic [7:0] value,
                              input presence_type mode, input int unsigned noise_pct);
      req_payload_type beat;
      beat.operation   = op;
      beat.write_value = value;
      beat.line_level  = 1'($urandom_range(0, 1));
      send_beat(beat);
      drain_command(mode, noise_pct);
   endtask

   // ticks while idle, read data must hold
   task automatic idle_ticks(input int unsigned count);
      req_payload_type beat;
      repeat (count) begin
         beat.operation   = ($urandom_range(0, 2) == 0) ?
                            3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI)) : OP_TICK;
         beat.write_value = 8'($urandom);
         beat.line_level  = 1'($urandom_range(0, 1));
         send_beat(beat);
      end
   endtask

   task automatic test_reset_values();
      run_command(OP_WRITE_BIT, 8'($urandom), PRES_RANDOM, 4);
      run_command(OP_READ_BIT, 8'($urandom), PRES_RANDOM, 4);
   endtask

   task automatic test_command_set();
      load_timing(2, 3, 3, 1, 2, 1, 1, 3);
      run_command(OP_RESET, 8'h00, PRES_ANSWER, 0);
      run_command(OP_RESET, 8'hFF, PRES_ABSENT, 0);
      run_command(OP_RESET, 8'h00, PRES_STUCK, 0);
      run_command(OP_WRITE_BIT, 8'hFE, PRES_RANDOM, 0);
      run_command(OP_WRITE_BIT, 8'h01, PRES_RANDOM, 0);
      run_command(OP_WRITE_BYTE, 8'h00, PRES_RANDOM, 0);
      run_command(OP_WRITE_BYTE, 8'hFF, PRES_RANDOM, 0);
      run_command(OP_READ_BIT, 8'h00, PRES_RANDOM, 0);
      run_command(OP_READ_BYTE, 8'hFF, PRES_RANDOM, 0);
      idle_ticks(3);
   endtask

   // every operation code, ticks and spares included, while a byte write runs
   task automatic test_busy_reject();
      req_payload_type beat;
      int unsigned     op;
      beat.operation   = OP_WRITE_BYTE;
      beat.write_value = 8'hA5;
      beat.line_level  = 1'b1;
      send_beat(beat);
      for (op = 32'(OP_TICK); op <= 32'(OP_SPARE_HI); op++) begin
         beat.operation   = op[2:0];
         beat.write_value = 8'($urandom);
         beat.line_level  = 1'($urandom_range(0, 1));
         send_beat(beat);
      end
      drain_command(PRES_RANDOM, 0);
   endtask

   // zero slot and pulse lengths act as one tick, zero timeouts fail at once
   task automatic test_zero_lengths();
      load_timing(0, 0, 0, 0, 0, 0, 0, 0);
      run_command(OP_RESET, 8'h00, PRES_ANSWER, 0);
      run_command(OP_WRITE_BYTE, 8'h3C, PRES_RANDOM, 0);
      run_command(OP_READ_BYTE, 8'h00, PRES_RANDOM, 0);
      load_timing(0, 2, 0, 0, 0, 0, 0, 0);
      run_command(OP_RESET, 8'h00, PRES_STUCK, 0);
   endtask

   // low times past the slot end and a late sample point, then near-minimum settings
   task automatic test_slot_edges();
      load_timing(1, 1, 1, 9, 12, 3, 200, 5);
      run_command(OP_WRITE_BYTE, 8'h5A, PRES_RANDOM, 0);
      run_command(OP_READ_BYTE, 8'h00, PRES_RANDOM, 0);
      load_timing(1, 1, 1, 1, 1, 1, 0, 2);
      run_command(OP_RESET, 8'h00, PRES_ANSWER, 0);
      run_command(OP_WRITE_BYTE, 8'h96, PRES_RANDOM, 0);
      run_command(OP_READ_BYTE, 8'h00, PRES_RANDOM, 0);
   endtask

   // widest timeouts, low times and sample delay, with a short pulse and slot
   task automatic test_upper_extremes();
      load_timing(3, 1023, 1023, 255, 255, 255, 255, 4);
      run_command(OP_RESET, 8'h00, PRES_ANSWER, 0);
      run_command(OP_RESET, 8'h00, PRES_RANDOM, 0);
      run_command(OP_READ_BYTE, 8'h00, PRES_RANDOM, 0);
      run_command(OP_WRITE_BIT, 8'h01, PRES_RANDOM, 0);
   endtask

   // mostly short timings, now and then anything in range
   function automatic int unsigned pick_time(input int unsigned lo, input int unsigned typical,
                                             input int unsigned top);
      if ($urandom_range(0, 99) < 5) return $urandom_range(lo, top);
      return $urandom_range(lo, typical);
   endfunction

   task automatic test_random_traffic(input int unsigned quota, input bit with_idling);
      int unsigned first;
      int unsigned phase_first;
      first   = beats_sent;
      idle_on = with_idling;
      while (beats_sent - first < quota) begin
         load_timing(pick_time(1, 24, 60), pick_time(1, 12, 1023), pick_time(1, 12, 1023),
                     pick_time(1, 10, 255), pick_time(1, 14, 255), pick_time(1, 8, 255),
                     pick_time(0, 12, 255), pick_time(2, 8, 24));
         phase_first = beats_sent;
         while (beats_sent - phase_first < 90 && beats_sent - first < quota) begin
            if ($urandom_range(0, 4) == 0) idle_ticks($urandom_range(1, 3));
            else run_command(3'($urandom_range(OP_RESET, OP_READ_BYTE)), 8'($urandom),
                             PRES_RANDOM, 8);
         end
      end
   endtask

   // response side back-pressure in bursts
   always @(posedge clock) begin
      if (stall_left != 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (idle_on && !reset && $urandom_range(0, 9) == 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= $urandom_range(0, 17);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   function automatic void check_field(input string name, input logic [9:0] want,
                                       input logic [9:0] got);
      if (want !== got) begin
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch on %s: expected %0d, got %0d", name, want, got);
      end
   endfunction

   // compare each response beat with the oldest prediction
   always @(posedge clock) begin : check_rsp
      rsp_payload_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_beats.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("response beat %h with none expected", rsp_payload);
         end else begin
            want = expected_beats.pop_front();
            check_field("drive_low", 10'(want.drive_low), 10'(rsp_payload.drive_low));
            check_field("busy_res", 10'(want.busy_res), 10'(rsp_payload.busy_res));
            check_field("done_res", 10'(want.done_res), 10'(rsp_payload.done_res));
            check_field("status", 10'(want.status), 10'(rsp_payload.status));
            check_field("read_data", 10'(want.read_data), 10'(rsp_payload.read_data));
         end
      end
   end

   // watchdog on handshake progress
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      clear_master();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_values();
      test_command_set();
      test_busy_reject();
      test_zero_lengths();
      test_slot_edges();
      test_upper_extremes();
      test_random_traffic(40, 1'b1);
      test_random_traffic(30, 1'b0);
      settle();
      repeat (8) @(posedge clock);
      if (mismatches == 0 && expected_beats.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
